// ----- hdl/pclp_pkg.sv -----
// Package for the paged circular log pointer engine: widths, codes and the
// structs passed between the front part, the queue, the divider and the back part.
// Depends on nothing.
`default_nettype none

package pclp_pkg;

	localparam int unsigned MAX_PAGES      = 16;
	localparam int unsigned MAX_PAGE_BYTES = 4096;

	localparam int unsigned FUNC_W     = 4;
	localparam int unsigned AMT_W      = 32;
	localparam int unsigned PC_W       = 5;
	localparam int unsigned PB_W       = 13;
	localparam int unsigned PAGE_W     = 4;
	localparam int unsigned OFF_W      = 12;
	localparam int unsigned LEN_W      = 13;
	localparam int unsigned BOFS_W     = 16;
	localparam int unsigned WP_W       = 17;
	localparam int unsigned RP_W       = 16;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 13;

	localparam int unsigned DVD_W            = 33;
	localparam int unsigned DVS_W            = 17;
	localparam int unsigned DIV_STEPS_WIDE   = DVD_W;
	localparam int unsigned DIV_STEPS_NARROW = DVS_W;
	localparam int unsigned DIV_CNT_W        = $clog2(DIV_STEPS_WIDE + 1);

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES = 4'd1;
	localparam logic [PC_W-1:0] CFG_PC_RESET = 5'd16;
	localparam logic [PB_W-1:0] CFG_PB_RESET = 13'd256;

	localparam logic [FUNC_W-1:0] FUNC_WRITE    = 4'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ     = 4'd1;
	localparam logic [FUNC_W-1:0] FUNC_SET_WR   = 4'd2;
	localparam logic [FUNC_W-1:0] FUNC_WR_LEFT  = 4'd3;
	localparam logic [FUNC_W-1:0] FUNC_WR_RIGHT = 4'd4;
	localparam logic [FUNC_W-1:0] FUNC_SET_RD   = 4'd5;
	localparam logic [FUNC_W-1:0] FUNC_RD_LEFT  = 4'd6;
	localparam logic [FUNC_W-1:0] FUNC_RD_RIGHT = 4'd7;
	localparam logic [FUNC_W-1:0] FUNC_RD_NEXT  = 4'd8;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 4'd9;
	localparam logic [FUNC_W-1:0] FUNC_QUERY    = 4'd10;

	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_ERASE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_WRITE = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ZERO_LEN = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_WRITE,
		JOB_READ,
		JOB_CLEAR
	} job_kind_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [WP_W-1:0] wp;
		logic [RP_W-1:0] rp;
		logic            same_page;
		logic            same_offset;
		logic            write_ahead;
	} rpt_t;

	typedef struct packed {
		job_kind_t         kind;
		logic              erase;
		logic [PAGE_W-1:0] page;
		logic [OFF_W-1:0]  off;
		logic [WP_W-1:0]   len;
		logic [PC_W-1:0]   pc;
		logic [PB_W-1:0]   pb;
		rpt_t              rpt;
	} job_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [PAGE_W-1:0] page;
		logic [OFF_W-1:0]  off;
		logic [LEN_W-1:0]  len;
		logic [BOFS_W-1:0] bofs;
		logic              last;
		rpt_t              rpt;
	} res_t;

	typedef struct packed {
		logic             start;
		logic             wide;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quot;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/paged_circular_log_pointer_engine.sv -----
// Paged circular log pointer engine top level; uses pclp_pkg, pclp_front, pclp_queue, pclp_back.
// A request's time in the front part is set by its shared divider (narrow or wide
// divisions, two to four per request). The first item of a request passes the queue
// and the back part's job and output registers, then one item per cycle while rsp_stall
// is low, up to 33 items; the next request is taken once the front part is free.
// Reset clears both pointers and loads page_count 16 and page_bytes 256.
`default_nettype none

module paged_circular_log_pointer_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [pclp_pkg::FUNC_W-1:0]      func,
	input  logic [pclp_pkg::AMT_W-1:0]       amount,
	input  logic                             erase_flag,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [1:0]                       cmd_kind,
	output logic [pclp_pkg::PAGE_W-1:0]      page_index,
	output logic [pclp_pkg::OFF_W-1:0]       page_offset,
	output logic [pclp_pkg::LEN_W-1:0]       segment_length,
	output logic [pclp_pkg::BOFS_W-1:0]      buffer_offset,
	output logic [1:0]                       status,
	output logic                             last,
	output logic [pclp_pkg::WP_W-1:0]        write_pointer,
	output logic [pclp_pkg::RP_W-1:0]        read_pointer,
	output logic                             same_page,
	output logic                             same_offset,
	output logic                             write_ahead,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pclp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pclp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pclp_pkg::*;

	job_t  front_job;
	job_t  back_job;
	logic  job_push;
	logic  queue_full;
	logic  queue_empty;
	logic  job_pop;
	res_t  res;

	pclp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.func       (func),
		.amount     (amount),
		.erase_flag (erase_flag),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.job        (front_job),
		.job_push   (job_push),
		.queue_full (queue_full)
	);

	pclp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (front_job),
		.full     (queue_full),
		.pop      (job_pop),
		.pop_job  (back_job),
		.empty    (queue_empty)
	);

	pclp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (back_job),
		.queue_empty (queue_empty),
		.pop         (job_pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.res         (res)
	);

	assign cmd_kind       = res.kind;
	assign page_index     = res.page;
	assign page_offset    = res.off;
	assign segment_length = res.len;
	assign buffer_offset  = res.bofs;
	assign status         = res.rpt.status;
	assign last           = res.last;
	assign write_pointer  = res.rpt.wp;
	assign read_pointer   = res.rpt.rp;
	assign same_page      = res.rpt.same_page;
	assign same_offset    = res.rpt.same_offset;
	assign write_ahead    = res.rpt.write_ahead;

endmodule

`default_nettype wire

// ----- hdl/pclp_div.sv -----
// Iterative restoring divider shared by the front part: one quotient bit per cycle.
// A narrow division takes 17 steps, a wide one 33. Uses pclp_pkg.
`default_nettype none

module pclp_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pclp_pkg::div_req_t  req,
	output pclp_pkg::div_rsp_t  rsp
);
	import pclp_pkg::*;

	logic [DVD_W-1:0]     dvd_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DVS_W+1:0]     diff;
	logic                 qbit;

	assign diff = {1'b0, rem_q, dvd_q[DVD_W-1]} - {2'b00, dvs_q};
	assign qbit = !diff[DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.wide ? DIV_CNT_W'(DIV_STEPS_WIDE) : DIV_CNT_W'(DIV_STEPS_NARROW);
				dvd_q  <= req.wide ? req.dividend
					: {req.dividend[DVS_W-1:0], {(DVD_W-DVS_W){1'b0}}};
				rem_q  <= '0;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[DVD_W-2:0], qbit};
				rem_q <= qbit ? diff[DVS_W-1:0] : {rem_q[DVS_W-2:0], dvd_q[DVD_W-1]};
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp = '{done: done_q, quot: dvd_q, rem: rem_q};

endmodule

`default_nettype wire

// ----- hdl/pclp_front.sv -----
// Front part: configuration registers, pointer state and request classification.
// Builds one job per request for the queue. Uses pclp_pkg and pclp_div.
`default_nettype none

module pclp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [pclp_pkg::FUNC_W-1:0]      func,
	input  logic [pclp_pkg::AMT_W-1:0]       amount,
	input  logic                             erase_flag,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pclp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pclp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output pclp_pkg::job_t                   job,
	output logic                             job_push,
	input  logic                             queue_full
);
	import pclp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_DIV1,
		S_DIV2,
		S_MUL,
		S_CMP,
		S_CMP_W,
		S_CMP_R,
		S_PUSH
	} state_t;

	state_t              state_q;
	logic [PC_W-1:0]     pc_cfg_q;
	logic [PB_W-1:0]     pb_cfg_q;
	logic [PC_W-1:0]     pc_q;
	logic [PB_W-1:0]     pb_q;
	logic [WP_W-1:0]     area_q;
	logic [FUNC_W-1:0]   func_q;
	logic [AMT_W-1:0]    amt_q;
	logic                er_q;
	logic [WP_W-1:0]     wp_q;
	logic [RP_W-1:0]     rp_q;
	job_kind_t           kind_q;
	logic [1:0]          status_q;
	logic [PAGE_W-1:0]   page_q;
	logic [OFF_W-1:0]    off_q;
	logic [PAGE_W-1:0]   nxt_q;
	logic [WP_W-1:0]     qw_q;
	logic                same_page_q;
	logic                same_offset_q;
	logic                write_ahead_q;
	div_req_t            div_req_q;
	div_rsp_t            div_rsp;

	logic [PC_W-1:0]     pc_sat;
	logic [PB_W-1:0]     pb_sat;
	logic [WP_W:0]       area_full;
	logic [WP_W-1:0]     wp_start;
	logic [WP_W:0]       wp_sum;
	logic [WP_W-1:0]     wp_wrapped;
	logic [WP_W:0]       rd_sum;
	logic [WP_W-1:0]     rd_wrapped;
	logic [WP_W-1:0]     rp_ext;
	logic [WP_W-1:0]     left_wp;
	logic [WP_W-1:0]     left_rp;
	logic                amt_big;
	logic [WP_W-1:0]     next_page_base;

	pclp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	always_comb begin
		pc_sat = (pc_cfg_q == '0) ? PC_W'(1)
			: ((pc_cfg_q > PC_W'(MAX_PAGES)) ? PC_W'(MAX_PAGES) : pc_cfg_q);
		pb_sat = (pb_cfg_q == '0) ? PB_W'(1)
			: ((pb_cfg_q > PB_W'(MAX_PAGE_BYTES)) ? PB_W'(MAX_PAGE_BYTES) : pb_cfg_q);
		area_full  = (WP_W+1)'(pc_sat) * (WP_W+1)'(pb_sat);
		wp_start   = (wp_q >= area_q) ? '0 : wp_q;
		wp_sum     = {1'b0, wp_start} + {1'b0, amt_q[WP_W-1:0]};
		wp_wrapped = (wp_sum > {1'b0, area_q}) ? WP_W'(wp_sum - {1'b0, area_q})
			: wp_sum[WP_W-1:0];
		rd_sum     = (WP_W+1)'(div_rsp.rem[RP_W-1:0]) + {1'b0, amt_q[WP_W-1:0]};
		rd_wrapped = (rd_sum >= {1'b0, area_q}) ? WP_W'(rd_sum - {1'b0, area_q})
			: rd_sum[WP_W-1:0];
		rp_ext     = {1'b0, rp_q};
		left_wp    = (wp_q >= div_rsp.rem) ? wp_q - div_rsp.rem
			: area_q - (div_rsp.rem - wp_q);
		left_rp    = (rp_ext >= div_rsp.rem) ? rp_ext - div_rsp.rem
			: area_q - (div_rsp.rem - rp_ext);
		amt_big    = amt_q > AMT_W'(area_q);
		next_page_base = WP_W'(nxt_q) * WP_W'(pb_q);
	end

	assign req_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign job_push  = (state_q == S_PUSH) && !queue_full;

	assign job = '{
		kind:  kind_q,
		erase: er_q,
		page:  page_q,
		off:   off_q,
		len:   amt_q[WP_W-1:0],
		pc:    pc_q,
		pb:    pb_q,
		rpt:   '{status: status_q, wp: wp_q, rp: rp_q, same_page: same_page_q,
			same_offset: same_offset_q, write_ahead: write_ahead_q}
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pc_cfg_q      <= CFG_PC_RESET;
			pb_cfg_q      <= CFG_PB_RESET;
			pc_q          <= '0;
			pb_q          <= '0;
			area_q        <= '0;
			func_q        <= '0;
			amt_q         <= '0;
			er_q          <= 1'b0;
			wp_q          <= '0;
			rp_q          <= '0;
			kind_q        <= JOB_NONE;
			status_q      <= STATUS_OK;
			page_q        <= '0;
			off_q         <= '0;
			nxt_q         <= '0;
			qw_q          <= '0;
			same_page_q   <= 1'b0;
			same_offset_q <= 1'b0;
			write_ahead_q <= 1'b0;
			div_req_q     <= '0;
		end else begin
			div_req_q.start <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_PAGE_COUNT: pc_cfg_q <= cfg_data[PC_W-1:0];
					CFG_PAGE_BYTES: pb_cfg_q <= cfg_data[PB_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						func_q  <= func;
						amt_q   <= amount;
						er_q    <= erase_flag;
						pc_q    <= pc_sat;
						pb_q    <= pb_sat;
						area_q  <= area_full[WP_W-1:0];
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					kind_q   <= JOB_NONE;
					status_q <= STATUS_OK;
					page_q   <= '0;
					off_q    <= '0;
					state_q  <= S_CMP;
					case (func_q)
						FUNC_WRITE, FUNC_READ: begin
							if (amt_q == '0) begin
								status_q <= STATUS_ZERO_LEN;
							end else if (amt_big) begin
								status_q <= STATUS_TOO_LONG;
							end else if (func_q == FUNC_WRITE) begin
								kind_q    <= JOB_WRITE;
								wp_q      <= wp_wrapped;
								div_req_q <= '{start: 1'b1, wide: 1'b0,
									dividend: DVD_W'(wp_start), divisor: DVS_W'(pb_q)};
								state_q   <= S_DIV1;
							end else begin
								kind_q    <= JOB_READ;
								div_req_q <= '{start: 1'b1, wide: 1'b0,
									dividend: DVD_W'(rp_q), divisor: area_q};
								state_q   <= S_DIV1;
							end
						end
						FUNC_SET_WR, FUNC_WR_LEFT, FUNC_SET_RD, FUNC_RD_LEFT: begin
							div_req_q <= '{start: 1'b1, wide: 1'b1,
								dividend: DVD_W'(amt_q), divisor: area_q};
							state_q   <= S_DIV1;
						end
						FUNC_WR_RIGHT: begin
							div_req_q <= '{start: 1'b1, wide: 1'b1,
								dividend: DVD_W'(wp_q) + DVD_W'(amt_q), divisor: area_q};
							state_q   <= S_DIV1;
						end
						FUNC_RD_RIGHT: begin
							div_req_q <= '{start: 1'b1, wide: 1'b1,
								dividend: DVD_W'(rp_q) + DVD_W'(amt_q), divisor: area_q};
							state_q   <= S_DIV1;
						end
						FUNC_RD_NEXT: begin
							div_req_q <= '{start: 1'b1, wide: 1'b0,
								dividend: DVD_W'(rp_q), divisor: DVS_W'(pb_q)};
							state_q   <= S_DIV1;
						end
						FUNC_CLEAR: begin
							kind_q <= JOB_CLEAR;
							wp_q   <= '0;
						end
						default: ;
					endcase
				end
				S_DIV1: begin
					if (div_rsp.done) begin
						state_q <= S_CMP;
						case (func_q)
							FUNC_WRITE: begin
								page_q <= div_rsp.quot[PAGE_W-1:0];
								off_q  <= div_rsp.rem[OFF_W-1:0];
							end
							FUNC_READ: begin
								rp_q      <= rd_wrapped[RP_W-1:0];
								div_req_q <= '{start: 1'b1, wide: 1'b0,
									dividend: DVD_W'(div_rsp.rem[RP_W-1:0]),
									divisor: DVS_W'(pb_q)};
								state_q   <= S_DIV2;
							end
							FUNC_SET_WR:   wp_q <= div_rsp.rem;
							FUNC_WR_LEFT:  wp_q <= left_wp;
							FUNC_WR_RIGHT: wp_q <= div_rsp.rem;
							FUNC_SET_RD:   rp_q <= div_rsp.rem[RP_W-1:0];
							FUNC_RD_LEFT:  rp_q <= left_rp[RP_W-1:0];
							FUNC_RD_RIGHT: rp_q <= div_rsp.rem[RP_W-1:0];
							FUNC_RD_NEXT: begin
								div_req_q <= '{start: 1'b1, wide: 1'b0,
									dividend: DVD_W'(div_rsp.quot[WP_W-1:0]) + DVD_W'(1),
									divisor: DVS_W'(pc_q)};
								state_q   <= S_DIV2;
							end
							default: ;
						endcase
					end
				end
				S_DIV2: begin
					if (div_rsp.done) begin
						if (func_q == FUNC_READ) begin
							page_q  <= div_rsp.quot[PAGE_W-1:0];
							off_q   <= div_rsp.rem[OFF_W-1:0];
							state_q <= S_CMP;
						end else begin
							nxt_q   <= div_rsp.rem[PAGE_W-1:0];
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					rp_q    <= next_page_base[RP_W-1:0];
					state_q <= S_CMP;
				end
				S_CMP: begin
					div_req_q <= '{start: 1'b1, wide: 1'b0,
						dividend: DVD_W'(wp_q), divisor: DVS_W'(pb_q)};
					state_q   <= S_CMP_W;
				end
				S_CMP_W: begin
					if (div_rsp.done) begin
						qw_q      <= div_rsp.quot[WP_W-1:0];
						div_req_q <= '{start: 1'b1, wide: 1'b0,
							dividend: DVD_W'(rp_q), divisor: DVS_W'(pb_q)};
						state_q   <= S_CMP_R;
					end
				end
				S_CMP_R: begin
					if (div_rsp.done) begin
						same_page_q   <= (qw_q == div_rsp.quot[WP_W-1:0]);
						same_offset_q <= (wp_q == rp_ext);
						write_ahead_q <= (wp_q > rp_ext);
						state_q       <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (!queue_full) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/pclp_queue.sv -----
// Short job queue between the front part and the back part.
// Holds QUEUE_DEPTH jobs in registers. Uses pclp_pkg.
`default_nettype none

module pclp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pclp_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output pclp_pkg::job_t  pop_job,
	output logic            empty
);
	import pclp_pkg::*;

	job_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_CW-1:0]  count_q;

	assign full    = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("job pushed into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("job popped from an empty queue");
`endif

endmodule

`default_nettype wire

// ----- hdl/pclp_back.sv -----
// Back part: walks one job at a time and emits one flash command item per cycle while
// rsp_stall is low, through an output register. Uses pclp_pkg.
`default_nettype none

module pclp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  pclp_pkg::job_t  job,
	input  logic            queue_empty,
	output logic            pop,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output pclp_pkg::res_t  res
);
	import pclp_pkg::*;

	logic               active_q;
	job_t               cur_q;
	logic [PAGE_W-1:0]  page_q;
	logic [OFF_W-1:0]   off_q;
	logic [WP_W-1:0]    rem_q;
	logic [BOFS_W-1:0]  done_q;
	logic               erased_q;
	logic               rsp_valid_q;
	res_t               res_q;

	logic [LEN_W-1:0]   chunk_full;
	logic               last_seg;
	logic [LEN_W-1:0]   chunk;
	logic               need_erase;
	logic               page_end;
	logic [PAGE_W-1:0]  next_page;
	logic [1:0]         seg_cmd;
	logic               emit;

	always_comb begin
		chunk_full = cur_q.pb - LEN_W'(off_q);
		last_seg   = (rem_q <= WP_W'(chunk_full));
		chunk      = last_seg ? rem_q[LEN_W-1:0] : chunk_full;
		need_erase = cur_q.erase && (off_q == '0) && !erased_q;
		page_end   = (PC_W'(page_q) == cur_q.pc - PC_W'(1));
		next_page  = page_end ? '0 : page_q + PAGE_W'(1);
		seg_cmd    = (cur_q.kind == JOB_WRITE) ? CMD_WRITE : CMD_READ;
	end

	assign pop       = !active_q && !queue_empty;
	assign emit      = active_q && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cur_q       <= '0;
			page_q      <= '0;
			off_q       <= '0;
			rem_q       <= '0;
			done_q      <= '0;
			erased_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (pop) begin
				active_q <= 1'b1;
				cur_q    <= job;
				page_q   <= job.page;
				off_q    <= job.off;
				rem_q    <= job.len;
				done_q   <= '0;
				erased_q <= 1'b0;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
				case (cur_q.kind)
					JOB_WRITE, JOB_READ: begin
						if ((cur_q.kind == JOB_WRITE) && need_erase) begin
							res_q <= '{kind: CMD_ERASE, page: page_q, off: '0, len: '0,
								bofs: '0, last: 1'b0, rpt: cur_q.rpt};
							erased_q <= 1'b1;
						end else begin
							res_q <= '{kind: seg_cmd, page: page_q, off: off_q, len: chunk,
								bofs: done_q, last: last_seg, rpt: cur_q.rpt};
							rem_q    <= rem_q - WP_W'(chunk);
							done_q   <= done_q + BOFS_W'(chunk);
							erased_q <= 1'b0;
							if (last_seg) begin
								active_q <= 1'b0;
							end else begin
								off_q  <= '0;
								page_q <= next_page;
							end
						end
					end
					JOB_CLEAR: begin
						res_q <= '{kind: CMD_ERASE, page: page_q, off: '0, len: '0,
							bofs: '0, last: page_end, rpt: cur_q.rpt};
						page_q <= next_page;
						if (page_end) begin
							active_q <= 1'b0;
						end
					end
					default: begin
						res_q <= '{kind: CMD_NONE, page: '0, off: '0, len: '0,
							bofs: '0, last: 1'b1, rpt: cur_q.rpt};
						active_q <= 1'b0;
					end
				endcase
			end
		end
	end

`ifndef SYNTH
	a_erase_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (res_q.kind == CMD_ERASE)) |->
		(res_q.len == '0) && (res_q.off == '0) && (res_q.bofs == '0))
		else $error("erase item carries a segment");
	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (res_q.kind == CMD_NONE)) |-> res_q.last)
		else $error("item without a command is not the last of its request");
	a_segment_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && ((res_q.kind == CMD_READ) || (res_q.kind == CMD_WRITE))) |->
		((res_q.len != '0) && (res_q.rpt.status == STATUS_OK)))
		else $error("data segment with zero length or error status");
	a_erase_before_write: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (cur_q.kind == JOB_WRITE) && need_erase) |=> (!res_q.last))
		else $error("erase ahead of a write closed the request");
`endif

endmodule

`default_nettype wire
